### rtl/bccr_pkg.sv
// Shared types, codes and constants for the block cache clock-replacement controller.
`default_nettype none

package bccr_pkg;

  // Fixed field widths of the request and result transactions.
  localparam int KIND_W   = 2;
  localparam int FILE_W   = 10;
  localparam int OFFSET_W = 40;
  localparam int BLOCK_W  = 28;
  localparam int SLOT_W   = 5;
  localparam int CNT_W    = 32;
  localparam int KEY_W    = FILE_W + BLOCK_W;

  // A single request never produces more than this many results.
  localparam int MAX_OUT  = 32;
  localparam int FOUND_W  = $clog2(MAX_OUT + 1);

  // Parameter defaults.
  localparam int DEF_ENTRIES     = 32;
  localparam int DEF_BLOCK_BYTES = 4096;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SYNC  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EVICT,
    ST_INSTALL,
    ST_CLEAR,
    ST_SYNC
  } bccr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the incoming request, restart the slot scan
    logic scan;        // lookup scan: read one slot, compare the previous one
    logic hit;         // commit a lookup hit and emit its result
    logic pick_fill;   // miss with free slots: the next unused slot is the victim
    logic evict_step;  // one step of the clock hand
    logic install;     // write the new key into the victim slot and emit
    logic clear;       // zero the counters and emit
    logic sync_scan;   // sync scan: read one slot, test the previous one
    logic sync_flush;  // emit the held writeback as the final result
  } bccr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lk_match;    // compared slot holds the requested key
    logic scan_done;   // every filled slot has been read and compared
    logic full;        // all slots are in use
    logic hand_ref;    // slot under the clock hand is referenced
    logic sync_done;   // sync scan has finished or reached the result limit
  } bccr_stat_t;

  // One result transaction.
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               fill_needed;
    logic               wb_valid;
    logic [FILE_W-1:0]  wb_file;
    logic [BLOCK_W-1:0] wb_block;
    logic               last;
    logic [CNT_W-1:0]   hits_total;
    logic [CNT_W-1:0]   misses_total;
  } bccr_res_t;

endpackage

`default_nettype wire

### rtl/bccr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bccr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/bccr_ctrl.sv
// Controller state machine that sequences lookup, eviction, install, sync and clear.
`default_nettype none

module bccr_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [bccr_pkg::KIND_W-1:0] in_kind,
  input  wire bccr_pkg::bccr_stat_t        stat,
  output bccr_pkg::bccr_cmd_t              cmd,
  output logic                             busy
);
  import bccr_pkg::*;

  bccr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          case (in_kind)
            KIND_CLEAR: state_nxt = ST_CLEAR;
            KIND_SYNC:  state_nxt = ST_SYNC;
            default:    state_nxt = ST_LOOKUP;
          endcase
        end
      end
      ST_LOOKUP: begin
        cmd.scan = 1'b1;
        if (stat.lk_match) begin
          cmd.hit   = 1'b1;
          state_nxt = ST_IDLE;
        end else if (stat.scan_done) begin
          if (stat.full) begin
            state_nxt = ST_EVICT;
          end else begin
            cmd.pick_fill = 1'b1;
            state_nxt     = ST_INSTALL;
          end
        end
      end
      ST_EVICT: begin
        cmd.evict_step = 1'b1;
        if (!stat.hand_ref) begin
          state_nxt = ST_INSTALL;
        end
      end
      ST_INSTALL: begin
        cmd.install = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SYNC: begin
        if (stat.sync_done) begin
          cmd.sync_flush = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.sync_scan = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/bccr_datapath.sv
// Datapath: tag RAM, per-slot flags, clock hand, counters and the result register.
`default_nettype none

module bccr_datapath #(
  parameter int ENTRIES     = bccr_pkg::DEF_ENTRIES,
  parameter int BLOCK_BYTES = bccr_pkg::DEF_BLOCK_BYTES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bccr_pkg::bccr_cmd_t           cmd,
  output bccr_pkg::bccr_stat_t               stat,
  input  wire logic [bccr_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [bccr_pkg::FILE_W-1:0]   in_file_id,
  input  wire logic [bccr_pkg::OFFSET_W-1:0] in_byte_offset,
  output bccr_pkg::bccr_res_t                res,
  output logic                               res_valid
);
  import bccr_pkg::*;

  localparam int IW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int BSH = $clog2(BLOCK_BYTES);
  localparam logic [CW-1:0]      ENT_C     = CW'(ENTRIES);
  localparam logic [IW-1:0]      LAST_IDX  = IW'(ENTRIES - 1);
  localparam logic [FOUND_W-1:0] MAX_OUT_C = FOUND_W'(MAX_OUT);

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] idx);
    logic [IW+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

  // Block number is the byte offset shifted by the block size, kept to the block field width.
  logic [OFFSET_W-1:0] blk_shift;
  assign blk_shift = in_byte_offset >> BSH;

  // Request registers.
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [FILE_W-1:0]  file_r, file_nxt;
  logic [BLOCK_W-1:0] block_r, block_nxt;

  // Scan, replacement and counter state.
  logic [CW-1:0]      scan_addr_r, scan_addr_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0]      victim_r, victim_nxt;
  logic               evict_r, evict_nxt;
  logic [IW-1:0]      hand_r, hand_nxt;
  logic [CW-1:0]      filled_r, filled_nxt;
  logic [CNT_W-1:0]   hits_r, hits_nxt;
  logic [CNT_W-1:0]   misses_r, misses_nxt;
  logic [ENTRIES-1:0] ref_r, ref_nxt;
  logic [ENTRIES-1:0] dirty_r, dirty_nxt;

  // Sync writeback held until the next one shows whether it is the final one.
  logic               pend_vld_r, pend_vld_nxt;
  logic [SLOT_W-1:0]  pend_slot_r, pend_slot_nxt;
  logic [BLOCK_W-1:0] pend_block_r, pend_block_nxt;
  logic [FOUND_W-1:0] found_r, found_nxt;

  bccr_res_t res_r, res_nxt;
  logic      res_valid_r, res_valid_nxt;

  // Tag RAM.
  logic               rd_en, wr_en;
  logic [IW-1:0]      rd_addr;
  logic [KEY_W-1:0]   rd_data;
  logic [FILE_W-1:0]  rd_file;
  logic [BLOCK_W-1:0] rd_block;
  logic               issue;
  logic               sync_hit;
  logic [IW-1:0]      hand_adv, victim_adv;

  bccr_ram #(
    .WIDTH(KEY_W),
    .DEPTH(ENTRIES)
  ) u_tag_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(victim_r),
    .wr_data({file_r, block_r}),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_file    = rd_data[KEY_W-1:BLOCK_W];
  assign rd_block   = rd_data[BLOCK_W-1:0];
  assign hand_adv   = (hand_r == LAST_IDX) ? '0 : hand_r + 1'b1;
  assign victim_adv = (victim_r == LAST_IDX) ? '0 : victim_r + 1'b1;

  assign issue    = (cmd.scan || cmd.sync_scan) && (scan_addr_r < filled_r) &&
                    (found_r < MAX_OUT_C);
  assign sync_hit = cmd.sync_scan && cmp_vld_r && (found_r < MAX_OUT_C) &&
                    dirty_r[cmp_idx_r] && (rd_file == file_r);

  assign stat.lk_match  = cmp_vld_r && (rd_data == {file_r, block_r});
  assign stat.scan_done = (scan_addr_r >= filled_r) && !cmp_vld_r;
  assign stat.full      = (filled_r == ENT_C);
  assign stat.hand_ref  = ref_r[hand_r];
  assign stat.sync_done = stat.scan_done || (found_r == MAX_OUT_C);

  always_comb begin
    kind_nxt       = kind_r;
    file_nxt       = file_r;
    block_nxt      = block_r;
    scan_addr_nxt  = scan_addr_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    victim_nxt     = victim_r;
    evict_nxt      = evict_r;
    hand_nxt       = hand_r;
    filled_nxt     = filled_r;
    hits_nxt       = hits_r;
    misses_nxt     = misses_r;
    ref_nxt        = ref_r;
    dirty_nxt      = dirty_r;
    pend_vld_nxt   = pend_vld_r;
    pend_slot_nxt  = pend_slot_r;
    pend_block_nxt = pend_block_r;
    found_nxt      = found_r;
    res_nxt        = res_r;
    res_valid_nxt  = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = scan_addr_r[IW-1:0];
    wr_en          = 1'b0;

    if (cmd.capture) begin
      kind_nxt      = in_kind;
      file_nxt      = in_file_id;
      block_nxt     = blk_shift[BLOCK_W-1:0];
      scan_addr_nxt = '0;
      cmp_vld_nxt   = 1'b0;
      found_nxt     = '0;
      pend_vld_nxt  = 1'b0;
    end

    // Scan pipeline: read one slot per cycle, compare it in the next.
    if (cmd.scan || cmd.sync_scan) begin
      cmp_vld_nxt = issue;
      if (issue) begin
        rd_en         = 1'b1;
        scan_addr_nxt = scan_addr_r + 1'b1;
        cmp_idx_nxt   = scan_addr_r[IW-1:0];
      end
    end

    if (cmd.hit) begin
      ref_nxt[cmp_idx_r] = 1'b1;
      if (kind_r == KIND_WRITE) begin
        dirty_nxt[cmp_idx_r] = 1'b1;
      end
      hits_nxt             = hits_r + 1'b1;
      res_valid_nxt        = 1'b1;
      res_nxt              = '0;
      res_nxt.hit          = 1'b1;
      res_nxt.slot         = to_slot(cmp_idx_r);
      res_nxt.last         = 1'b1;
      res_nxt.hits_total   = hits_r + 1'b1;
      res_nxt.misses_total = misses_r;
    end

    if (cmd.pick_fill) begin
      victim_nxt = filled_r[IW-1:0];
      evict_nxt  = 1'b0;
    end

    // Second chance: a referenced slot loses its bit and the hand moves on.
    if (cmd.evict_step) begin
      if (ref_r[hand_r]) begin
        ref_nxt[hand_r] = 1'b0;
        hand_nxt        = hand_adv;
      end else begin
        victim_nxt = hand_r;
        evict_nxt  = 1'b1;
        rd_en      = 1'b1;
        rd_addr    = hand_r;
      end
    end

    if (cmd.install) begin
      wr_en                = 1'b1;
      ref_nxt[victim_r]    = 1'b1;
      dirty_nxt[victim_r]  = (kind_r == KIND_WRITE);
      if (evict_r) begin
        hand_nxt = victim_adv;
      end else begin
        filled_nxt = filled_r + 1'b1;
      end
      misses_nxt           = misses_r + 1'b1;
      res_valid_nxt        = 1'b1;
      res_nxt              = '0;
      res_nxt.slot         = to_slot(victim_r);
      res_nxt.fill_needed  = 1'b1;
      if (evict_r && dirty_r[victim_r]) begin
        res_nxt.wb_valid = 1'b1;
        res_nxt.wb_file  = rd_file;
        res_nxt.wb_block = rd_block;
      end
      res_nxt.last         = 1'b1;
      res_nxt.hits_total   = hits_r;
      res_nxt.misses_total = misses_r + 1'b1;
    end

    if (cmd.clear) begin
      hits_nxt      = '0;
      misses_nxt    = '0;
      res_valid_nxt = 1'b1;
      res_nxt       = '0;
      res_nxt.last  = 1'b1;
    end

    if (sync_hit) begin
      dirty_nxt[cmp_idx_r] = 1'b0;
      if (pend_vld_r) begin
        res_valid_nxt        = 1'b1;
        res_nxt              = '0;
        res_nxt.slot         = pend_slot_r;
        res_nxt.wb_valid     = 1'b1;
        res_nxt.wb_file      = file_r;
        res_nxt.wb_block     = pend_block_r;
        res_nxt.hits_total   = hits_r;
        res_nxt.misses_total = misses_r;
      end
      pend_vld_nxt   = 1'b1;
      pend_slot_nxt  = to_slot(cmp_idx_r);
      pend_block_nxt = rd_block;
      found_nxt      = found_r + 1'b1;
    end

    if (cmd.sync_flush && pend_vld_r) begin
      res_valid_nxt        = 1'b1;
      res_nxt              = '0;
      res_nxt.slot         = pend_slot_r;
      res_nxt.wb_valid     = 1'b1;
      res_nxt.wb_file      = file_r;
      res_nxt.wb_block     = pend_block_r;
      res_nxt.last         = 1'b1;
      res_nxt.hits_total   = hits_r;
      res_nxt.misses_total = misses_r;
      pend_vld_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r   <= 1'b0;
      hand_r      <= '0;
      filled_r    <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      ref_r       <= '0;
      dirty_r     <= '0;
      pend_vld_r  <= 1'b0;
      found_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      cmp_vld_r   <= cmp_vld_nxt;
      hand_r      <= hand_nxt;
      filled_r    <= filled_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      ref_r       <= ref_nxt;
      dirty_r     <= dirty_nxt;
      pend_vld_r  <= pend_vld_nxt;
      found_r     <= found_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    file_r       <= file_nxt;
    block_r      <= block_nxt;
    scan_addr_r  <= scan_addr_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    victim_r     <= victim_nxt;
    evict_r      <= evict_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_block_r <= pend_block_nxt;
    res_r        <= res_nxt;
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;

endmodule

`default_nettype wire

### rtl/block_cache_clock_replacement_top.sv
// Top level of the block cache tag and second-chance replacement controller.
//
//   Channel   Ports                                   Transfer
//   -------   -------------------------------------   -------------------------------
//   request   start, busy, in_kind, in_file_id,       start high while busy is low
//             in_byte_offset
//   result    out_valid, out_hit ... out_misses_total one cycle per strobe, no stall
//
// A request is captured, then the tag RAM is scanned one slot per cycle through its
// single registered read port. A miss on a full cache then steps the clock hand,
// up to ENTRIES + 1 steps. A sync delivers its writebacks spread over the scan,
// at most one per cycle.
// Reset is synchronous and active low; it clears all slot flags, the hand, the
// fill count and both counters, and needs no clearing pass over the tag RAM.
// The receiver cannot stall, so each result transaction is shown for one cycle.
`default_nettype none

module block_cache_clock_replacement_top #(
  // Number of cache slots, from 2 to 32.
  parameter int ENTRIES     = bccr_pkg::DEF_ENTRIES,
  // Block size in bytes; a power of two from 4096 to 65536.
  parameter int BLOCK_BYTES = bccr_pkg::DEF_BLOCK_BYTES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bccr_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [bccr_pkg::FILE_W-1:0]   in_file_id,
  input  wire logic [bccr_pkg::OFFSET_W-1:0] in_byte_offset,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [bccr_pkg::SLOT_W-1:0]        out_slot,
  output logic                               out_fill_needed,
  output logic                               out_writeback_valid,
  output logic [bccr_pkg::FILE_W-1:0]        out_writeback_file,
  output logic [bccr_pkg::BLOCK_W-1:0]       out_writeback_block,
  output logic                               out_last,
  output logic [bccr_pkg::CNT_W-1:0]         out_hits_total,
  output logic [bccr_pkg::CNT_W-1:0]         out_misses_total
);
  import bccr_pkg::*;

  bccr_cmd_t  cmd;
  bccr_stat_t stat;
  bccr_res_t  res;

  // The controller walks each transaction through its phases; it sees only the
  // request kind and the datapath status.
  bccr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_kind(in_kind),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the keys in the tag RAM and the reference and dirty bits,
  // the clock hand, the fill count and the counters in flip-flops. Slots fill in
  // order and are never invalidated, so a slot is valid exactly when its index
  // is below the fill count.
  bccr_datapath #(
    .ENTRIES    (ENTRIES),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (in_kind),
    .in_file_id    (in_file_id),
    .in_byte_offset(in_byte_offset),
    .res           (res),
    .res_valid     (out_valid)
  );

  assign out_hit             = res.hit;
  assign out_slot            = res.slot;
  assign out_fill_needed     = res.fill_needed;
  assign out_writeback_valid = res.wb_valid;
  assign out_writeback_file  = res.wb_file;
  assign out_writeback_block = res.wb_block;
  assign out_last            = res.last;
  assign out_hits_total      = res.hits_total;
  assign out_misses_total    = res.misses_total;

endmodule

`default_nettype wire

### rtl/bccr_checker.sv
// Port-level checker for the block cache controller and its bind to the top level.
`default_nettype none

module bccr_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         out_valid,
  input wire logic                         out_hit,
  input wire logic                         out_fill_needed,
  input wire logic                         out_writeback_valid,
  input wire logic [bccr_pkg::FILE_W-1:0]  out_writeback_file,
  input wire logic [bccr_pkg::BLOCK_W-1:0] out_writeback_block,
  input wire logic                         out_last
);

  // Reset leaves the block idle with no result on the way.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // An accepted request always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // A hit is a single, complete result with no fill and no writeback.
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_last && !out_fill_needed && !out_writeback_valid)
    else $error("hit result carries fill or writeback");

  // A fill result belongs to a miss and ends its request.
  a_fill_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_needed |-> !out_hit && out_last)
    else $error("fill result flagged as hit or not last");

  // Writeback fields read as zero on every result that asks for no writeback.
  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_writeback_valid |->
      out_writeback_file == '0 && out_writeback_block == '0)
    else $error("writeback fields set without a writeback");

endmodule

bind block_cache_clock_replacement_top bccr_checker u_bccr_checker (.*);

`default_nettype wire

### bench/tb_block_cache_clock_replacement_top.sv
// Self-checking testbench for the block cache tag and second-chance replacement controller.
`default_nettype none

module tb_block_cache_clock_replacement_top;
  import bccr_pkg::*;

  // The block is built with its default geometry, and the bench predicts it with the same.
  localparam int SLOTS        = DEF_ENTRIES;
  localparam int BLK_BYTES    = DEF_BLOCK_BYTES;
  localparam int RANDOM_N     = 240;
  // Working set of keys for the random part. It is a bit larger than the cache, so that
  // hot keys hit while the cold ones keep the clock hand busy with evictions.
  localparam int FILE_POOL    = 4;
  localparam int KEY_POOL     = 44;
  localparam int HOT_KEYS     = 24;
  // A miss on a full cache may sweep the hand once all the way around, so this covers
  // the slowest request that has no result at all (a sync with nothing dirty).
  localparam int DRAIN_CYCLES = 2 * SLOTS + 16;
  // The slowest transaction and the longest sender gap both stay far below this limit.
  localparam int CYCLE_LIMIT  = 400000;

  // One request transaction as it is driven onto the input ports.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [FILE_W-1:0]   file_id;
    logic [OFFSET_W-1:0] offset;
  } cache_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [FILE_W-1:0]   in_file_id = '0;
  logic [OFFSET_W-1:0] in_byte_offset = '0;
  logic                out_valid;
  logic                out_hit;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_fill_needed;
  logic                out_writeback_valid;
  logic [FILE_W-1:0]   out_writeback_file;
  logic [BLOCK_W-1:0]  out_writeback_block;
  logic                out_last;
  logic [CNT_W-1:0]    out_hits_total;
  logic [CNT_W-1:0]    out_misses_total;

  // Requests that still wait to be taken by the block, and the results that the
  // accepted ones are bound to produce, oldest first.
  cache_req_t cache_requests[$];
  bccr_res_t  predicted_results[$];

  // The bench's own view of the tag store and the replacement state.
  bit                 slot_valid[SLOTS];
  logic [FILE_W-1:0]  slot_file[SLOTS];
  logic [BLOCK_W-1:0] slot_block[SLOTS];
  bit                 slot_referenced[SLOTS];
  bit                 slot_dirty[SLOTS];
  int                 hand_pos = 0;
  int                 slots_filled = 0;
  logic [CNT_W-1:0]   hit_count = '0;
  logic [CNT_W-1:0]   miss_count = '0;

  // Run statistics for the closing summary.
  int n_accesses = 0;
  int n_syncs = 0;
  int n_clears = 0;
  int n_hits = 0;
  int n_misses = 0;
  int n_evictions = 0;
  int n_writebacks = 0;
  int n_checked = 0;
  int n_failures = 0;
  int cycle_count = 0;

  // Sender pacing: gap_left idle cycles before the next request, and calm_left
  // requests still to be sent back to back.
  int  gap_left = 0;
  int  calm_left = 0;
  bit  took;
  bccr_res_t oldest;

  block_cache_clock_replacement_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_file_id          (in_file_id),
    .in_byte_offset      (in_byte_offset),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_slot            (out_slot),
    .out_fill_needed     (out_fill_needed),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_file  (out_writeback_file),
    .out_writeback_block (out_writeback_block),
    .out_last            (out_last),
    .out_hits_total      (out_hits_total),
    .out_misses_total    (out_misses_total)
  );

  always #5 clk = ~clk;

  // Apply one accepted request to the predicted cache state and queue the
  // result transactions that it must produce.
  function automatic void apply_cache_request(cache_req_t rq);
    bccr_res_t          res;
    logic [63:0]        block_wide;
    logic [BLOCK_W-1:0] blk;
    int                 found;
    int                 victim;
    int                 h;
    int                 dirty_total;
    int                 emitted;
    block_wide = 64'(rq.offset) / BLK_BYTES;
    blk = block_wide[BLOCK_W-1:0];
    res = '0;
    case (rq.kind)
      KIND_CLEAR: begin
        n_clears++;
        hit_count = '0;
        miss_count = '0;
        res.last = 1'b1;
        predicted_results = {predicted_results, res};
      end
      KIND_SYNC: begin
        // Count first, so that the final writeback can carry the last flag.
        n_syncs++;
        dirty_total = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && slot_dirty[i] && slot_file[i] == rq.file_id) dirty_total++;
        end
        if (dirty_total > MAX_OUT) dirty_total = MAX_OUT;
        emitted = 0;
        for (int i = 0; i < SLOTS && emitted < dirty_total; i++) begin
          if (slot_valid[i] && slot_dirty[i] && slot_file[i] == rq.file_id) begin
            slot_dirty[i] = 1'b0;
            emitted++;
            res = '0;
            res.slot = SLOT_W'(i);
            res.wb_valid = 1'b1;
            res.wb_file = rq.file_id;
            res.wb_block = slot_block[i];
            res.last = (emitted == dirty_total);
            res.hits_total = hit_count;
            res.misses_total = miss_count;
            predicted_results = {predicted_results, res};
            n_writebacks++;
          end
        end
      end
      default: begin
        n_accesses++;
        found = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (found < 0 && slot_valid[i] && slot_file[i] == rq.file_id && slot_block[i] == blk)
            found = i;
        end
        if (found >= 0) begin
          n_hits++;
          hit_count = hit_count + 1'b1;
          slot_referenced[found] = 1'b1;
          if (rq.kind == KIND_WRITE) slot_dirty[found] = 1'b1;
          res.hit = 1'b1;
          res.slot = SLOT_W'(found);
        end else begin
          n_misses++;
          miss_count = miss_count + 1'b1;
          if (slots_filled < SLOTS) begin
            victim = slots_filled;
            slots_filled++;
          end else begin
            // Second chance: referenced slots lose their bit as the hand passes,
            // and the first slot found without one is taken.
            n_evictions++;
            h = hand_pos;
            victim = h;
            for (int g = 0; g <= SLOTS; g++) begin
              if (slot_referenced[h]) begin
                slot_referenced[h] = 1'b0;
                h = (h + 1) % SLOTS;
              end else begin
                victim = h;
                break;
              end
            end
            hand_pos = (victim + 1) % SLOTS;
            if (slot_dirty[victim]) begin
              res.wb_valid = 1'b1;
              res.wb_file = slot_file[victim];
              res.wb_block = slot_block[victim];
              n_writebacks++;
            end
          end
          slot_valid[victim] = 1'b1;
          slot_file[victim] = rq.file_id;
          slot_block[victim] = blk;
          slot_referenced[victim] = 1'b1;
          slot_dirty[victim] = (rq.kind == KIND_WRITE);
          res.slot = SLOT_W'(victim);
          res.fill_needed = 1'b1;
        end
        res.last = 1'b1;
        res.hits_total = hit_count;
        res.misses_total = miss_count;
        predicted_results = {predicted_results, res};
      end
    endcase
  endfunction

  // Most gaps are short, a few are long, and now and then a run of requests
  // goes out back to back.
  function automatic int draw_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_request(logic [KIND_W-1:0] kind, logic [FILE_W-1:0] file_id,
                                        logic [OFFSET_W-1:0] offset);
    cache_req_t rq;
    rq.kind = kind;
    rq.file_id = file_id;
    rq.offset = offset;
    cache_requests = {cache_requests, rq};
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      n_failures++;
    end
  endtask

  // Driver. The request at the head of the queue sits on the input ports with
  // start high until the block takes it; the transaction is accepted at an edge
  // where start is high and busy is low. Start is assigned once per edge, so a
  // request that follows right away keeps start high without a dip.
  always @(posedge clk) begin
    took = rst_n && start && !busy;
    if (took) begin
      apply_cache_request(cache_requests[0]);
      cache_requests.delete(0);
      gap_left = draw_gap();
    end
    if (!rst_n) begin
      gap_left = 0;
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (cache_requests.size() > 0) begin
      start <= 1'b1;
      in_kind <= cache_requests[0].kind;
      in_file_id <= cache_requests[0].file_id;
      in_byte_offset <= cache_requests[0].offset;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor. The receiver cannot stall, so every strobe is one result
  // transaction, and it must match the oldest prediction field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: result transaction with none predicted, actual slot %0d", $time,
                 out_slot);
        n_failures++;
      end else begin
        oldest = predicted_results[0];
        predicted_results.delete(0);
        check_field("hit", 64'(oldest.hit), 64'(out_hit));
        check_field("slot", 64'(oldest.slot), 64'(out_slot));
        check_field("fill_needed", 64'(oldest.fill_needed), 64'(out_fill_needed));
        check_field("writeback_valid", 64'(oldest.wb_valid), 64'(out_writeback_valid));
        check_field("writeback_file", 64'(oldest.wb_file), 64'(out_writeback_file));
        check_field("writeback_block", 64'(oldest.wb_block), 64'(out_writeback_block));
        check_field("last", 64'(oldest.last), 64'(out_last));
        check_field("hits_total", 64'(oldest.hits_total), 64'(out_hits_total));
        check_field("misses_total", 64'(oldest.misses_total), 64'(out_misses_total));
        n_checked++;
      end
    end
  end

  // Watchdog: a hung handshake must not stall the run forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d requests and %0d results still outstanding", $time,
               cache_requests.size(), predicted_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [FILE_W-1:0]  file_pool[FILE_POOL];
    logic [FILE_W-1:0]  key_file[KEY_POOL];
    logic [BLOCK_W-1:0] key_block[KEY_POOL];
    int                 roll;
    int                 k;
    logic [KIND_W-1:0]  kind;

    // Directed part. It opens on the extremes of the key: file 0 at offset 0 and
    // file 1023 at the very last byte, whose block number is all ones in 28 bits.
    queue_request(KIND_READ, 10'd0, 40'd0);
    queue_request(KIND_READ, 10'd0, OFFSET_W'(BLK_BYTES - 1));         // same block, a hit
    queue_request(KIND_WRITE, 10'h3FF, '1);                            // miss, starts dirty
    queue_request(KIND_WRITE, 10'h3FF, OFFSET_W'(40'hFF_FFFF_F000));   // write hit
    queue_request(KIND_READ, 10'h3FF, OFFSET_W'(40'hFF_FFFF_F7A5));    // read hit on dirty
    queue_request(KIND_SYNC, 10'h3FF, '1);                             // one writeback
    queue_request(KIND_SYNC, 10'h3FF, 40'd0);                          // nothing dirty left
    queue_request(KIND_SYNC, 10'd5, 40'd0);                            // file not cached
    // Same block number in another file must not hit.
    queue_request(KIND_READ, 10'h200, OFFSET_W'(40'h80_0000_0000));
    queue_request(KIND_READ, 10'd1, 40'd0);
    queue_request(KIND_CLEAR, 10'h155, OFFSET_W'(40'h55_5555_5555));
    // Several dirty blocks of one file, then a sync that writes all of them back.
    queue_request(KIND_WRITE, 10'd0, 40'd0);
    queue_request(KIND_WRITE, 10'd0, OFFSET_W'(BLK_BYTES + 17));
    queue_request(KIND_WRITE, 10'd0, OFFSET_W'(2 * BLK_BYTES));
    queue_request(KIND_WRITE, 10'd0, OFFSET_W'(3 * BLK_BYTES + BLK_BYTES - 1));
    queue_request(KIND_WRITE, 10'd1, OFFSET_W'(5 * BLK_BYTES));
    queue_request(KIND_SYNC, 10'd0, OFFSET_W'(40'hAA_AAAA_AAAA));
    queue_request(KIND_READ, 10'd0, OFFSET_W'(2 * BLK_BYTES + 100));
    queue_request(KIND_SYNC, 10'd1, 40'd0);
    queue_request(KIND_CLEAR, 10'd0, 40'd0);

    // Random part. Most requests go to a small pool of keys, so that hits, a full
    // cache, sweeps of the clock hand and dirty victims all come up often; the
    // rest is noise over the whole key space.
    for (int i = 0; i < FILE_POOL; i++) file_pool[i] = FILE_W'($urandom);
    for (int i = 0; i < KEY_POOL; i++) begin
      key_file[i] = file_pool[$urandom_range(0, FILE_POOL - 1)];
      key_block[i] = BLOCK_W'($urandom);
    end
    key_block[0] = '0;
    key_block[1] = '1;
    for (int n = 0; n < RANDOM_N; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        kind = KIND_W'($urandom_range(0, 3));
        queue_request(kind, FILE_W'($urandom), OFFSET_W'({$urandom(), $urandom()}));
      end else if (roll < 13) begin
        queue_request(KIND_CLEAR, FILE_W'($urandom), OFFSET_W'({$urandom(), $urandom()}));
      end else if (roll < 25) begin
        queue_request(KIND_SYNC, file_pool[$urandom_range(0, FILE_POOL - 1)],
                      OFFSET_W'({$urandom(), $urandom()}));
      end else begin
        k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, HOT_KEYS - 1)
                                       : $urandom_range(0, KEY_POOL - 1);
        kind = (roll < 62) ? KIND_READ : KIND_WRITE;
        queue_request(kind, key_file[k],
                      OFFSET_W'(64'(key_block[k]) * BLK_BYTES
                                + $urandom_range(0, BLK_BYTES - 1)));
      end
    end

    // Synchronous reset, released once.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every request has been taken and every predicted result seen,
    // then give the block time to finish a last request that has no result.
    while (cache_requests.size() != 0 || predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d reads/writes (%0d hits, %0d misses, %0d clock evictions), %0d syncs,",
             n_accesses, n_hits, n_misses, n_evictions, n_syncs);
    $display("%0d counter clears and %0d writebacks; %0d results checked, %0d mismatches.",
             n_clears, n_writebacks, n_checked, n_failures);
    if (n_failures == 0 && predicted_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
